### hdl/kv_pair_tokenizer_top_assert.svh
// Assertion macros for the key=value tokenizer top level.
`ifndef KV_PAIR_TOKENIZER_TOP_ASSERT_SVH
`define KV_PAIR_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KVT_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KVT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### hdl/kvt_pkg.sv
// Package for the key=value tokenizer: types, codes and character helpers.
package kvt_pkg;

  localparam int MaxResults = 4;

  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_KEY    = 3'd1,
    PH_VSTART = 3'd2,
    PH_BARE   = 3'd3,
    PH_QUOTED = 3'd4,
    PH_QESC   = 3'd5,
    PH_SKIP   = 3'd6,
    PH_HALT   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_KEY    = 3'd0,
    KIND_VALUE  = 3'd1,
    KIND_PAIR   = 3'd2,
    KIND_CANCEL = 3'd3,
    KIND_LINE   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       found;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChVt) ||
               (c == ChFf) || (c == ChCr);
  endfunction

endpackage

### hdl/kv_pair_tokenizer_top.sv
// Top level of the streaming key=value tokenizer.
//
// Input channel: in_valid/in_ready carry one line byte (line_byte) and an
// end-of-line mark (line_last) per request. Output channel: out_valid/out_ready
// carry one token result per request: kind, data_byte, found_pair, run_last.
// Configuration: cfg_wr_en/cfg_wr_data write tail_mode; write only while idle.
//
// Each accepted byte is decoded in the cycle it is accepted and its zero to
// four results are loaded into a four-entry result buffer; the first result
// is visible in the cycle after acceptance. While the receiver is ready, the
// buffer drains one result per cycle, so a byte with one result or none
// sustains one byte per cycle; more results hold the input until they drain
// through the single output port. A new byte is taken in the cycle the last
// buffered result is delivered. When the receiver stalls, the buffer holds
// its head result and in_ready stays low until its last result is delivered.
// Reset (rst, synchronous) empties the buffer, returns the scan to the start
// of a token, clears the pair flag and sets tail_mode to strict.
module kv_pair_tokenizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] line_byte,
  input  logic       line_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] data_byte,
  output logic       found_pair,
  output logic       run_last
);

  `include "kv_pair_tokenizer_top_assert.svh"

  logic              tail_mode;
  kvt_pkg::phase_t   phase, phase_mid, phase_next;
  logic              quote_single, quote_mid, quote_next;
  logic              pairs_seen, pairs_mid, pairs_next;
  kvt_pkg::res_t     res [kvt_pkg::MaxResults];
  logic [2:0]        res_cnt;
  kvt_pkg::res_t     rbuf [kvt_pkg::MaxResults];
  logic [2:0]        cnt;
  logic              in_acc, out_acc, searching;
  logic [7:0]        qch;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign searching = tail_mode && !pairs_seen;
  assign qch       = quote_single ? kvt_pkg::ChSquote : kvt_pkg::ChDquote;

  // Hold the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      tail_mode <= cfg_wr_data;
    end
  end

  // Next state: byte step, then end-of-line return to reset values.
  always_comb begin
    phase_mid = phase;
    quote_mid = quote_single;
    pairs_mid = pairs_seen;
    unique case (phase)
      kvt_pkg::PH_START: begin
        if (kvt_pkg::is_space(line_byte)) begin
          phase_mid = kvt_pkg::PH_START;
        end else if (line_byte == kvt_pkg::ChEq) begin
          phase_mid = searching ? kvt_pkg::PH_SKIP : kvt_pkg::PH_HALT;
        end else begin
          phase_mid = kvt_pkg::PH_KEY;
        end
      end
      kvt_pkg::PH_KEY: begin
        if (line_byte == kvt_pkg::ChEq) begin
          phase_mid = kvt_pkg::PH_VSTART;
        end else if (kvt_pkg::is_space(line_byte)) begin
          phase_mid = searching ? kvt_pkg::PH_START : kvt_pkg::PH_HALT;
        end
      end
      kvt_pkg::PH_VSTART: begin
        if (line_byte == kvt_pkg::ChDquote || line_byte == kvt_pkg::ChSquote) begin
          quote_mid = (line_byte == kvt_pkg::ChSquote);
          phase_mid = kvt_pkg::PH_QUOTED;
        end else if (kvt_pkg::is_space(line_byte)) begin
          pairs_mid = 1'b1;
          phase_mid = kvt_pkg::PH_START;
        end else begin
          phase_mid = kvt_pkg::PH_BARE;
        end
      end
      kvt_pkg::PH_BARE: begin
        if (kvt_pkg::is_space(line_byte)) begin
          pairs_mid = 1'b1;
          phase_mid = kvt_pkg::PH_START;
        end
      end
      kvt_pkg::PH_QUOTED: begin
        if (line_byte == qch) begin
          pairs_mid = 1'b1;
          phase_mid = kvt_pkg::PH_START;
        end else if (line_byte == kvt_pkg::ChBslash) begin
          phase_mid = kvt_pkg::PH_QESC;
        end
      end
      kvt_pkg::PH_QESC: begin
        phase_mid = kvt_pkg::PH_QUOTED;
      end
      kvt_pkg::PH_SKIP: begin
        if (kvt_pkg::is_space(line_byte)) begin
          phase_mid = kvt_pkg::PH_START;
        end
      end
      default: begin
        phase_mid = kvt_pkg::PH_HALT;
      end
    endcase

    if (line_last) begin
      phase_next = kvt_pkg::PH_START;
      quote_next = 1'b0;
      pairs_next = 1'b0;
    end else begin
      phase_next = phase_mid;
      quote_next = quote_mid;
      pairs_next = pairs_mid;
    end
  end

  // Outputs: results caused by the byte, then by the line end.
  always_comb begin
    logic [2:0] n;
    logic       open_value;
    n = 3'd0;
    open_value = 1'b0;
    for (int i = 0; i < kvt_pkg::MaxResults; i++) begin
      res[i] = '{kind: kvt_pkg::KIND_KEY, data: 8'h00, found: 1'b0};
    end

    unique case (phase)
      kvt_pkg::PH_START: begin
        if (!kvt_pkg::is_space(line_byte) && line_byte != kvt_pkg::ChEq) begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_KEY, data: line_byte, found: 1'b0};
          n = n + 3'd1;
        end
      end
      kvt_pkg::PH_KEY: begin
        if (kvt_pkg::is_space(line_byte)) begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_CANCEL, data: 8'h00, found: 1'b0};
          n = n + 3'd1;
        end else if (line_byte != kvt_pkg::ChEq) begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_KEY, data: line_byte, found: 1'b0};
          n = n + 3'd1;
        end
      end
      kvt_pkg::PH_VSTART: begin
        if (line_byte == kvt_pkg::ChDquote || line_byte == kvt_pkg::ChSquote) begin
          n = n;
        end else if (kvt_pkg::is_space(line_byte)) begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_PAIR, data: 8'h00, found: 1'b0};
          n = n + 3'd1;
        end else begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_VALUE, data: line_byte, found: 1'b0};
          n = n + 3'd1;
        end
      end
      kvt_pkg::PH_BARE: begin
        if (kvt_pkg::is_space(line_byte)) begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_PAIR, data: 8'h00, found: 1'b0};
        end else begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_VALUE, data: line_byte, found: 1'b0};
        end
        n = n + 3'd1;
      end
      kvt_pkg::PH_QUOTED: begin
        if (line_byte == qch) begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_PAIR, data: 8'h00, found: 1'b0};
          n = n + 3'd1;
        end else if (line_byte != kvt_pkg::ChBslash) begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_VALUE, data: line_byte, found: 1'b0};
          n = n + 3'd1;
        end
      end
      kvt_pkg::PH_QESC: begin
        // Pass an unknown escape through as both bytes.
        if (line_byte != qch && line_byte != kvt_pkg::ChBslash) begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_VALUE, data: kvt_pkg::ChBslash,
                          found: 1'b0};
          n = n + 3'd1;
        end
        res[n[1:0]] = '{kind: kvt_pkg::KIND_VALUE, data: line_byte, found: 1'b0};
        n = n + 3'd1;
      end
      default: begin
        n = n;
      end
    endcase

    if (line_last) begin
      unique case (phase_mid) inside
        kvt_pkg::PH_KEY: begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_CANCEL, data: 8'h00, found: 1'b0};
          n = n + 3'd1;
        end
        kvt_pkg::PH_QESC: begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_VALUE, data: kvt_pkg::ChBslash,
                          found: 1'b0};
          n = n + 3'd1;
          res[n[1:0]] = '{kind: kvt_pkg::KIND_PAIR, data: 8'h00, found: 1'b0};
          n = n + 3'd1;
          open_value = 1'b1;
        end
        kvt_pkg::PH_VSTART, kvt_pkg::PH_BARE, kvt_pkg::PH_QUOTED: begin
          res[n[1:0]] = '{kind: kvt_pkg::KIND_PAIR, data: 8'h00, found: 1'b0};
          n = n + 3'd1;
          open_value = 1'b1;
        end
        default: begin
          n = n;
        end
      endcase
      res[n[1:0]] = '{kind: kvt_pkg::KIND_LINE, data: 8'h00,
                      found: pairs_mid | open_value};
      n = n + 3'd1;
    end
    res_cnt = n;
  end

  // Advance the scan state on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= kvt_pkg::PH_START;
      quote_single <= 1'b0;
      pairs_seen   <= 1'b0;
    end else if (in_acc) begin
      phase        <= phase_next;
      quote_single <= quote_next;
      pairs_seen   <= pairs_next;
    end
  end

  // Take a new byte once the buffer is empty or delivers its last result.
  assign in_ready = (cnt == 3'd0) || ((cnt == 3'd1) && out_ready);

  // Result buffer: load on accept, shift down on each delivered request.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (in_acc) begin
      cnt <= res_cnt;
    end else if (out_acc) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < kvt_pkg::MaxResults; i++) begin
        rbuf[i] <= res[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < kvt_pkg::MaxResults - 1; i++) begin
        rbuf[i] <= rbuf[i + 1];
      end
    end
  end

  assign out_valid  = (cnt != 3'd0);
  assign kind       = rbuf[0].kind;
  assign data_byte  = rbuf[0].data;
  assign found_pair = rbuf[0].found;
  assign run_last   = (cnt == 3'd1);

  // Assertions.
  `KVT_ASSERT_NOW(a_ready_only_on_last, in_ready && out_valid, run_last,
                  "input taken while more than one result is pending")
  `KVT_ASSERT_NOW(a_found_only_on_line, out_valid && (kind != kvt_pkg::KIND_LINE),
                  !found_pair, "found_pair set outside a line-done result")
  `KVT_ASSERT_NOW(a_marker_data_zero,
                  out_valid && (kind == kvt_pkg::KIND_PAIR || kind == kvt_pkg::KIND_CANCEL ||
                  kind == kvt_pkg::KIND_LINE), data_byte == 8'h00,
                  "marker result carries a nonzero byte")
  `KVT_ASSERT_NEXT(a_line_end_resets, in_acc && line_last,
                   (phase == kvt_pkg::PH_START) && !pairs_seen && !quote_single,
                   "scan state not returned to start after line end")

endmodule
